/* hw/rtl/dmo3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmo3_pkg
// Shared types and constants of the order-3 Markov trainer.
// ----------------------------------------------------------------------------
package dmo3_pkg;

   typedef enum logic [1:0] {
      REQ_CLEAR      = 2'd0,
      REQ_TRAIN      = 2'd1,
      REQ_QUERY_BASE = 2'd2,
      REQ_QUERY_TRAN = 2'd3
   } req_kind_type;

   localparam int ROW_ENTRIES = 4;
   localparam int Q_BITS      = 16;
   localparam int HIST_FULL   = 3;

   typedef struct packed {
      logic clear;
      logic train;
      logic query_load;
      logic sum_en;
      logic upd_en;
      logic div_en;
   } cmd_type;

   typedef struct packed {
      logic tx_need;
      logic sum_done;
      logic div_done;
   } status_type;

endpackage

/* hw/rtl/dmo3_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmo3_ctrl
// Sequencer for train, clear and query transactions.
// ----------------------------------------------------------------------------
module dmo3_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dmo3_pkg::cmd_type    cmd,
   input  dmo3_pkg::status_type status
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_UPDATE = 5'b00010,
      S_SUM    = 5'b00100,
      S_DIV    = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (dmo3_pkg::req_kind_type'(req_type))
                  dmo3_pkg::REQ_CLEAR: cmd.clear = 1'b1;
                  dmo3_pkg::REQ_TRAIN: begin
                     cmd.train = 1'b1;
                     if (status.tx_need) begin
                        state_in = S_UPDATE;
                     end
                  end
                  dmo3_pkg::REQ_QUERY_BASE, dmo3_pkg::REQ_QUERY_TRAN: begin
                     cmd.query_load = 1'b1;
                     state_in       = S_SUM;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_UPDATE: begin
            cmd.upd_en = 1'b1;
            state_in   = S_IDLE;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            if (status.sum_done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (status.div_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* hw/rtl/dmo3_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmo3_dpath
// Count storage, context history, row summation and restoring divider.
// ----------------------------------------------------------------------------
module dmo3_dpath #(
   parameter int COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_type,
   input  logic [1:0]           req_base_code,
   input  logic                 req_base_valid,
   input  logic                 req_seq_last,
   input  logic [5:0]           req_query_context,
   input  logic [1:0]           req_query_symbol,
   input  dmo3_pkg::cmd_type    cmd,
   output dmo3_pkg::status_type status,
   output logic [15:0]          rsp_probability,
   output logic                 rsp_answered_kind,
   output logic [7:0]           rsp_answered_index
);

   localparam int ACC_BITS = COUNT_BITS + 2;
   localparam int REM_BITS = COUNT_BITS + 3;
   localparam int DEPTH    = 256;

   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      vbit_ff;
   logic [COUNT_BITS-1:0] mem_rd_ff;
   logic                  vld_rd_ff;
   logic [7:0]            rd_addr;
   logic                  we;
   logic [COUNT_BITS-1:0] wdata;

   logic [COUNT_BITS-1:0] base_ff [dmo3_pkg::ROW_ENTRIES];
   logic [5:0]            hist_ff;
   logic [1:0]            fill_ff;
   logic [7:0]            tidx_ff;

   logic                  kind_ff;
   logic [5:0]            qctx_ff;
   logic [1:0]            qsym_ff;
   logic [2:0]            step_ff;
   logic [1:0]            sel_ff;
   logic [COUNT_BITS-1:0] bsel_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [4:0]            dcnt_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [15:0]           quo_ff;

   logic [COUNT_BITS-1:0] mem_val;
   logic [COUNT_BITS-1:0] sum_val;
   logic [REM_BITS-1:0]   rem_sh;
   logic [5:0]            hist_shift;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (&v) ? v : v + COUNT_BITS'(1);
   endfunction

   assign mem_val    = vld_rd_ff ? mem_rd_ff : COUNT_BITS'(1);
   assign sum_val    = kind_ff ? mem_val : bsel_ff;
   assign rem_sh     = {rem_ff[REM_BITS-2:0], 1'b0};
   assign hist_shift = {hist_ff[3:0], req_base_code};

   assign status.tx_need  = req_base_valid && (fill_ff == 2'(dmo3_pkg::HIST_FULL));
   assign status.sum_done = (step_ff == 3'(dmo3_pkg::ROW_ENTRIES));
   assign status.div_done = (dcnt_ff == 5'(dmo3_pkg::Q_BITS));

   assign rd_addr = cmd.train ? {hist_ff, req_base_code} : {qctx_ff, step_ff[1:0]};
   assign we      = cmd.upd_en;
   assign wdata   = sat_inc(mem_val);

   always_ff @(posedge clock) begin
      mem_rd_ff <= mem[rd_addr];
      if (we) begin
         mem[tidx_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         vbit_ff <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         vld_rd_ff <= vbit_ff[rd_addr];
         if (we) begin
            vbit_ff[tidx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < dmo3_pkg::ROW_ENTRIES; i++) begin
            base_ff[i] <= COUNT_BITS'(1);
         end
         hist_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.train) begin
         tidx_ff <= {hist_ff, req_base_code};
         if (req_base_valid) begin
            base_ff[req_base_code] <= sat_inc(base_ff[req_base_code]);
         end
         if (!req_base_valid || req_seq_last) begin
            hist_ff <= '0;
            fill_ff <= '0;
         end else begin
            hist_ff <= hist_shift;
            if (fill_ff != 2'(dmo3_pkg::HIST_FULL)) begin
               fill_ff <= fill_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_load) begin
         kind_ff <= (dmo3_pkg::req_kind_type'(req_type) == dmo3_pkg::REQ_QUERY_TRAN);
         qctx_ff <= req_query_context;
         qsym_ff <= req_query_symbol;
         step_ff <= '0;
         acc_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.sum_en) begin
            if (step_ff != 3'(dmo3_pkg::ROW_ENTRIES)) begin
               bsel_ff <= base_ff[step_ff[1:0]];
               sel_ff  <= step_ff[1:0];
            end
            if (step_ff != 3'd0) begin
               acc_ff <= acc_ff + ACC_BITS'(sum_val);
               if (sel_ff == qsym_ff) begin
                  cnt_ff <= sum_val;
               end
            end
            step_ff <= step_ff + 3'd1;
         end
         if (cmd.div_en) begin
            if (dcnt_ff == 5'd0) begin
               rem_ff <= REM_BITS'(cnt_ff);
               quo_ff <= '0;
            end else if (rem_sh >= REM_BITS'(acc_ff)) begin
               rem_ff <= rem_sh - REM_BITS'(acc_ff);
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + 5'd1;
         end
      end
   end

   assign rsp_probability    = quo_ff;
   assign rsp_answered_kind  = kind_ff;
   assign rsp_answered_index = kind_ff ? {qctx_ff, qsym_ff} : {6'd0, qsym_ff};

endmodule

/* hw/rtl/dna_markov_order3_trainer_unit.sv */
`timescale 1ns / 1ps
// Train: an update state is added for a transition count write (read-modify-write).
// Query: row sum, restoring divider, then response; one query in flight at a time.
// Synchronous active-high reset: all counts read as 1, history cleared.
// ----------------------------------------------------------------------------
// dna_markov_order3_trainer_unit
// Third-order Markov chain trainer over DNA bases with Q0.16 probability queries.
// ----------------------------------------------------------------------------
module dna_markov_order3_trainer_unit #(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [1:0]  req_base_code,
   input  logic        req_base_valid,
   input  logic        req_seq_last,
   input  logic [5:0]  req_query_context,
   input  logic [1:0]  req_query_symbol,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_probability,
   output logic        rsp_answered_kind,
   output logic [7:0]  rsp_answered_index
);

   dmo3_pkg::cmd_type    cmd;
   dmo3_pkg::status_type status;

   dmo3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dmo3_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_base_code      (req_base_code),
      .req_base_valid     (req_base_valid),
      .req_seq_last       (req_seq_last),
      .req_query_context  (req_query_context),
      .req_query_symbol   (req_query_symbol),
      .cmd                (cmd),
      .status             (status),
      .rsp_probability    (rsp_probability),
      .rsp_answered_kind  (rsp_answered_kind),
      .rsp_answered_index (rsp_answered_index)
   );

endmodule

/* tb/sv/tb_dna_markov_order3_trainer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dna_markov_order3_trainer_unit
// Drives clear, train and query transactions into the order-3 Markov trainer,
// keeps its own copy of the base and transition counts, and checks every
// probability answer field by field against that copy.
// ----------------------------------------------------------------------------
module tb_dna_markov_order3_trainer_unit;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [1:0]  req_base_code;
   logic        req_base_valid;
   logic        req_seq_last;
   logic [5:0]  req_query_context;
   logic [1:0]  req_query_symbol;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_probability;
   logic        rsp_answered_kind;
   logic [7:0]  rsp_answered_index;

   typedef struct packed {
      logic [15:0] prob;
      logic        kind;
      logic [7:0]  index;
   } answer_type;

   localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

   logic [31:0] base_count [4];
   logic [31:0] tran_count [256];
   logic [5:0]  hist_ctx;
   logic [1:0]  hist_len;
   answer_type  answers_due [$];
   int          mismatches;
   int          orphans;
   bit          quiet;
   bit          busy_sink;

   dna_markov_order3_trainer_unit uut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == COUNT_TOP) ? v : v + 32'd1;
   endfunction

   function automatic logic [15:0] ratio(logic [31:0] c, logic [33:0] tot);
      logic [63:0] q;
      if (tot == 0) return 16'd0;
      q = {16'd0, c, 16'd0} / {30'd0, tot};
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   task automatic wipe_counts();
      for (int i = 0; i < 4; i++) base_count[i] = 32'd1;
      for (int i = 0; i < 256; i++) tran_count[i] = 32'd1;
      hist_ctx = '0;
      hist_len = '0;
   endtask

   task automatic predict(logic [1:0] t, logic [1:0] code, logic ok, logic last,
                          logic [5:0] ctx, logic [1:0] sym);
      logic [33:0] tot;
      logic [7:0]  row;
      answer_type  a;
      case (t)
         dmo3_pkg::REQ_CLEAR: wipe_counts();
         dmo3_pkg::REQ_TRAIN: begin
            if (ok) begin
               base_count[code] = bump(base_count[code]);
               if (hist_len == 2'd3)
                  tran_count[{hist_ctx, code}] = bump(tran_count[{hist_ctx, code}]);
               hist_ctx = {hist_ctx[3:0], code};
               if (hist_len != 2'd3) hist_len++;
            end else begin
               hist_ctx = '0;
               hist_len = '0;
            end
            if (last) begin
               hist_ctx = '0;
               hist_len = '0;
            end
         end
         dmo3_pkg::REQ_QUERY_BASE: begin
            tot = 34'(base_count[0]) + base_count[1] + base_count[2] + base_count[3];
            a.prob = ratio(base_count[sym], tot);
            a.kind = 1'b0;
            a.index = {6'd0, sym};
            answers_due.insert(answers_due.size(), a);
         end
         default: begin
            row = {ctx, 2'd0};
            tot = 34'(tran_count[row]) + tran_count[row + 1] + tran_count[row + 2]
                  + tran_count[row + 3];
            a.prob = ratio(tran_count[{ctx, sym}], tot);
            a.kind = 1'b1;
            a.index = {ctx, sym};
            answers_due.insert(answers_due.size(), a);
         end
      endcase
   endtask

   task automatic send(logic [1:0] t, logic [1:0] code = '0, logic ok = 1'b1,
                       logic last = 1'b0, logic [5:0] ctx = '0, logic [1:0] sym = '0);
      while (!quiet && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= t;
      req_base_code     <= code;
      req_base_valid    <= ok;
      req_seq_last      <= last;
      req_query_context <= ctx;
      req_query_symbol  <= sym;
      do @(posedge clock); while (req_stall);
      predict(t, code, ok, last, ctx, sym);
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            orphans++;
            $display("unexpected answer prob=%0d kind=%0d index=%0d",
                     rsp_probability, rsp_answered_kind, rsp_answered_index);
         end else begin
            a = answers_due.pop_front();
            if (a.prob !== rsp_probability || a.kind !== rsp_answered_kind ||
                a.index !== rsp_answered_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp prob=%0d kind=%0d index=%0d, got %0d %0d %0d",
                           a.prob, a.kind, a.index, rsp_probability,
                           rsp_answered_kind, rsp_answered_index);
            end
         end
      end
      rsp_stall <= (!quiet && busy_sink) ? ($urandom_range(99) < 32) : 1'b0;
   end

   task automatic test_directed();
      for (int s = 0; s < 4; s++)
         send(dmo3_pkg::REQ_QUERY_BASE, 2'd0, 1'b1, 1'b0, 6'd0, s[1:0]);
      send(dmo3_pkg::REQ_QUERY_TRAN, 2'd0, 1'b1, 1'b0, 6'd63, 2'd3);
      // A A A then T with sequence end, then runs broken by an invalid base and sequence end
      for (int i = 0; i < 3; i++) send(dmo3_pkg::REQ_TRAIN, 2'd0);
      send(dmo3_pkg::REQ_TRAIN, 2'd3, 1'b1, 1'b1);
      send(dmo3_pkg::REQ_QUERY_TRAN, 2'd0, 1'b1, 1'b0, 6'd0, 2'd3);
      send(dmo3_pkg::REQ_TRAIN, 2'd3); send(dmo3_pkg::REQ_TRAIN, 2'd3);
      send(dmo3_pkg::REQ_TRAIN, 2'd2, 1'b0);
      send(dmo3_pkg::REQ_TRAIN, 2'd3); send(dmo3_pkg::REQ_TRAIN, 2'd3);
      send(dmo3_pkg::REQ_TRAIN, 2'd3);
      send(dmo3_pkg::REQ_TRAIN, 2'd1, 1'b1, 1'b1);
      send(dmo3_pkg::REQ_QUERY_TRAN, 2'd0, 1'b1, 1'b0, 6'd63, 2'd1);
      send(dmo3_pkg::REQ_QUERY_BASE, 2'd0, 1'b1, 1'b1, 6'd0, 2'd3);
      send(dmo3_pkg::REQ_CLEAR, 2'd3, 1'b0, 1'b1, 6'd63, 2'd3);
      send(dmo3_pkg::REQ_QUERY_TRAN, 2'd0, 1'b1, 1'b0, 6'd63, 2'd1);
      send(dmo3_pkg::REQ_QUERY_BASE, 2'd0, 1'b1, 1'b0, 6'd0, 2'd0);
   endtask

   task automatic test_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         quiet = (i >= n / 3 && i < n / 3 + 150);
         k = $urandom_range(99);
         if (k < 65) begin
            // runs of mostly valid bases, mostly within a few contexts
            send(dmo3_pkg::REQ_TRAIN,
                 (k < 30) ? 2'($urandom_range(1)) : 2'($urandom_range(3)),
                 $urandom_range(19) != 0, $urandom_range(24) == 0);
         end else if (k < 80)
            send(dmo3_pkg::REQ_QUERY_TRAN, 2'($urandom), 1'($urandom), 1'($urandom),
                 ($urandom_range(1) ? 6'($urandom_range(3)) : 6'($urandom_range(63))),
                 2'($urandom_range(3)));
         else if (k < 97)
            send(dmo3_pkg::REQ_QUERY_BASE, 2'($urandom), 1'($urandom), 1'($urandom),
                 6'($urandom), 2'($urandom_range(3)));
         else
            send(dmo3_pkg::REQ_CLEAR, 2'($urandom), 1'($urandom), 1'($urandom),
                 6'($urandom), 2'($urandom));
      end
      quiet = 0;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = dmo3_pkg::REQ_CLEAR;
      req_base_code     = '0;
      req_base_valid    = 1'b0;
      req_seq_last      = 1'b0;
      req_query_context = '0;
      req_query_symbol  = '0;
      rsp_stall         = 1'b0;
      mismatches        = 0;
      orphans           = 0;
      quiet             = 0;
      busy_sink         = 1;
      wipe_counts();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1430);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && orphans == 0)
         $display("dna_markov_order3_trainer_unit test passed");
      else
         $display("dna_markov_order3_trainer_unit test failed");
      $finish;
   end

   initial begin
      #3ms;
      $display("dna_markov_order3_trainer_unit test failed");
      $finish;
   end

endmodule
